// ----- hdl/kps_pkg.sv -----
`timescale 1ns / 1ps

package kps_pkg;

  // Fixed widths of the key matrix pins and the code table.
  localparam int unsigned ColW      = 4;
  localparam int unsigned DriveW    = 4;
  localparam int unsigned CodeW     = 8;
  localparam int unsigned TicksW    = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned TableRows = 4;
  localparam int unsigned HeldW     = 2;

  // Depth of the queue between the classifier and the scanner engine.
  localparam int unsigned QueueDepth = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegDebounce = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRow0     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRow1     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRow2     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRow3     = 3'd4;

  localparam logic [TicksW-1:0] DebounceReset = 16'd25;

  // One classified column sample.
  typedef struct packed {
    logic [ColW-1:0]  lows;     // pressed columns, masked to the real ones
    logic [HeldW-1:0] low_col;  // lowest pressed column
    logic             any_low;  // at least one column pressed
  } sample_t;

endpackage

// ----- hdl/kps_if.sv -----
`timescale 1ns / 1ps

interface kps_in_if;
  logic                      valid;
  logic                      ready;
  logic [kps_pkg::ColW-1:0]  column_levels;

  modport source (output valid, output column_levels, input ready);
  modport sink (input valid, input column_levels, output ready);
endinterface

interface kps_out_if;
  logic                        valid;
  logic                        ready;
  logic [kps_pkg::DriveW-1:0]  row_drive;
  logic                        key_valid;
  logic [kps_pkg::CodeW-1:0]   key_code;

  modport source (output valid, output row_drive, output key_valid, output key_code,
                  input ready);
  modport sink (input valid, input row_drive, input key_valid, input key_code,
                output ready);
endinterface

interface kps_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [kps_pkg::CfgIdxW-1:0]   index;
  logic [kps_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/kps_front.sv -----
`timescale 1ns / 1ps

module kps_front #(
  parameter int unsigned COLUMNS = 4
) (
  kps_in_if.sink            in_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output kps_pkg::sample_t  push_data_o
);

  localparam logic [kps_pkg::ColW-1:0] ColMask =
    (COLUMNS >= kps_pkg::ColW) ? '1 : kps_pkg::ColW'((1 << COLUMNS) - 1);

  logic [kps_pkg::ColW-1:0]  lows;
  logic [kps_pkg::HeldW-1:0] low_col;

  assign lows = ~in_i.column_levels & ColMask;

  // Lowest pressed column; column three also stands for no column at all.
  always_comb begin
    priority if (lows[0]) begin
      low_col = 2'd0;
    end else if (lows[1]) begin
      low_col = 2'd1;
    end else if (lows[2]) begin
      low_col = 2'd2;
    end else begin
      low_col = 2'd3;
    end
  end

  assign push_data_o  = '{lows: lows, low_col: low_col, any_low: |lows};
  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

endmodule

// ----- hdl/kps_queue.sv -----
`timescale 1ns / 1ps

module kps_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  kps_pkg::sample_t  push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output kps_pkg::sample_t  pop_data_o
);

  localparam int unsigned Depth = kps_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  kps_pkg::sample_t entry_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hdl/kps_back.sv -----
`timescale 1ns / 1ps

module kps_back #(
  parameter int unsigned ROWS = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  kps_cfg_if.sink           cfg_i,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  kps_pkg::sample_t  pop_data_i,
  kps_out_if.source         key_o
);

  localparam int unsigned RowW = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam logic [1:0] PhScan     = 2'd0;
  localparam logic [1:0] PhDebounce = 2'd1;
  localparam logic [1:0] PhRelease  = 2'd2;

  logic [kps_pkg::TicksW-1:0]   debounce_q;
  logic [kps_pkg::CfgDataW-1:0] codes_q [kps_pkg::TableRows];

  logic [RowW-1:0]              row_q, row_d;
  logic [1:0]                   phase_q, phase_d;
  logic [kps_pkg::TicksW-1:0]   wait_q, wait_d;
  logic [kps_pkg::HeldW-1:0]    held_q, held_d;

  logic                         out_valid_q, out_valid_d;
  logic [kps_pkg::DriveW-1:0]   drive_q, drive_d;
  logic                         key_valid_q, key_valid_d;
  logic [kps_pkg::CodeW-1:0]    code_q, code_d;

  logic                         pop;
  logic                         held_low;
  logic [RowW-1:0]              row_next;
  logic [kps_pkg::CfgDataW-1:0] row_codes;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= kps_pkg::DebounceReset;
      for (int i = 0; i < int'(kps_pkg::TableRows); i++) begin
        codes_q[i] <= '0;
      end
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        kps_pkg::RegDebounce: debounce_q <= cfg_i.data[kps_pkg::TicksW-1:0];
        kps_pkg::RegRow0:     codes_q[0] <= cfg_i.data;
        kps_pkg::RegRow1:     codes_q[1] <= cfg_i.data;
        kps_pkg::RegRow2:     codes_q[2] <= cfg_i.data;
        kps_pkg::RegRow3:     codes_q[3] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // The engine takes a sample whenever the output register is free or drains.
  assign pop_ready_o = !out_valid_q || key_o.ready;
  assign pop         = pop_valid_i && pop_ready_o;
  assign held_low    = pop_data_i.lows[held_q];
  assign row_next    = (row_q == RowW'(ROWS - 1)) ? '0 : row_q + 1'b1;
  assign row_codes   = codes_q[2'(row_q)];

  always_comb begin
    row_d       = row_q;
    phase_d     = phase_q;
    wait_d      = wait_q;
    held_d      = held_q;
    out_valid_d = out_valid_q;
    drive_d     = drive_q;
    key_valid_d = key_valid_q;
    code_d      = code_q;
    if (pop) begin
      key_valid_d = 1'b0;
      code_d      = '0;
      unique case (phase_q)
        PhDebounce: begin
          if (wait_q != '0) begin
            wait_d = wait_q - 1'b1;
          end else if (held_low) begin
            phase_d = PhRelease;
          end else begin
            row_d   = row_next;
            phase_d = PhScan;
          end
        end
        PhRelease: begin
          if (!held_low) begin
            key_valid_d = 1'b1;
            // Rows past the table report code zero.
            if (4'(row_q) < 4'(kps_pkg::TableRows)) begin
              code_d = row_codes[8*held_q +: 8];
            end
            row_d   = row_next;
            phase_d = PhScan;
          end
        end
        default: begin
          phase_d = PhScan;
          if (!pop_data_i.any_low) begin
            row_d = row_next;
          end else begin
            held_d  = pop_data_i.low_col;
            wait_d  = debounce_q;
            phase_d = PhDebounce;
          end
        end
      endcase
      // Rows beyond the four pins leave every pin high.
      drive_d     = (4'(row_d) >= 4'd4) ? 4'hF : ~(4'b0001 << row_d);
      out_valid_d = 1'b1;
    end else if (key_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      phase_q     <= PhScan;
      wait_q      <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      row_q       <= row_d;
      phase_q     <= phase_d;
      wait_q      <= wait_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    drive_q     <= drive_d;
    key_valid_q <= key_valid_d;
    code_q      <= code_d;
  end

  assign key_o.valid     = out_valid_q;
  assign key_o.row_drive = drive_q;
  assign key_o.key_valid = key_valid_q;
  assign key_o.key_code  = code_q;

endmodule

// ----- hdl/matrix_keypad_scanner_core.sv -----
`timescale 1ns / 1ps

// Key matrix scanner with debounce. Each item on column_i is one scan tick:
// the column pin levels sampled while the row pins are at the levels given by
// the previous result's row_drive (row 0 low after reset). Every item yields
// exactly one result on key_o with the row levels for the next tick, and with
// key_valid set and key_code taken from the code table on the tick on which a
// debounced key is released. The block takes one item per clock cycle while
// key_o takes its results. Each item passes through the queue into the
// engine, which updates its state once per item. A two-entry queue between
// the column classifier and the scanner engine, together with the result
// register, lets the input side keep accepting while a result waits to be
// taken. Configuration writes (debounce length, four rows of codes) are
// always accepted and must only be made while no item is in flight.

module matrix_keypad_scanner_core #(
  parameter int unsigned ROWS    = 4,
  parameter int unsigned COLUMNS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kps_in_if.sink     column_i,
  kps_cfg_if.sink    cfg_i,
  kps_out_if.source  key_o
);

  // Classified samples flow from the front into the queue, and from the
  // queue into the scanner engine.
  logic              push_valid;
  logic              push_ready;
  kps_pkg::sample_t  push_data;
  logic              pop_valid;
  logic              pop_ready;
  kps_pkg::sample_t  pop_data;

  // The front masks the columns and finds the lowest pressed one.
  kps_front #(
    .COLUMNS (COLUMNS)
  ) u_front (
    .in_i         (column_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  kps_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // The back runs the scan, debounce and release phases and holds the
  // configuration registers and the result register.
  kps_back #(
    .ROWS (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .key_o       (key_o)
  );

endmodule

// ----- verif/tb_matrix_keypad_scanner_core.sv -----
`timescale 1ns / 1ps

// The stimulus models a physical keypad rather than raw pin levels. Each pending
// item holds the set of keys that are down during one scan tick. The driver turns
// that set into column levels for the row that the scanner drives at that moment.
// The scanner's row is known from the predictor, which is updated on every
// accepted item. Some items carry raw column levels instead, as pin noise.
module tb_matrix_keypad_scanner_core;

  // Scanner phases as the predictor tracks them.
  typedef enum logic [1:0] {
    PhScan,
    PhDebounce,
    PhRelease
  } scan_phase_e;

  // One scan tick as the keypad presents it. When raw is set, raw_levels goes to
  // the pins as it is. Otherwise keys (bit 4*row+column) says which keys are down.
  typedef struct packed {
    logic                     raw;
    logic [kps_pkg::ColW-1:0] raw_levels;
    logic [15:0]              keys;
  } pad_tick_t;

  // One result item: the row levels for the next tick and an optional key report.
  typedef struct packed {
    logic [kps_pkg::DriveW-1:0] row_drive;
    logic                       key_valid;
    logic [kps_pkg::CodeW-1:0]  key_code;
  } key_report_t;

  // Debounce lengths of the random phases. They stay short so that keys get
  // confirmed often. The longest length has a phase of its own at the end.
  localparam int unsigned DebouncePlan [6] = '{1, 0, 3, 2, 7, 4};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Every input of the block has a known value from time zero.
  logic                         col_valid  = 1'b0;
  logic [kps_pkg::ColW-1:0]     col_levels = '1;
  logic                         out_ready  = 1'b0;
  logic                         cfg_valid  = 1'b0;
  logic [kps_pkg::CfgIdxW-1:0]  cfg_index  = kps_pkg::RegDebounce;
  logic [kps_pkg::CfgDataW-1:0] cfg_data   = '0;

  kps_in_if  col_if ();
  kps_out_if key_if ();
  kps_cfg_if cfg_if ();

  assign col_if.valid         = col_valid;
  assign col_if.column_levels = col_levels;
  assign key_if.ready         = out_ready;
  assign cfg_if.valid         = cfg_valid;
  assign cfg_if.index         = cfg_index;
  assign cfg_if.data          = cfg_data;

  matrix_keypad_scanner_core #(
    .ROWS   (4),
    .COLUMNS(4)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .column_i(col_if),
    .cfg_i   (cfg_if),
    .key_o   (key_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state and its copy of the configuration registers, at reset values.
  logic [1:0]                   scan_row     = '0;
  scan_phase_e                  scan_state   = PhScan;
  logic [kps_pkg::TicksW-1:0]   settle_count = '0;
  logic [kps_pkg::HeldW-1:0]    held_col     = '0;
  logic [kps_pkg::TicksW-1:0]   debounce_len = kps_pkg::DebounceReset;
  logic [kps_pkg::CfgDataW-1:0] code_rows [kps_pkg::TableRows] = '{default: '0};

  pad_tick_t   pending_ticks [$];
  key_report_t expected_reports [$];

  int unsigned fault_count    = 0;
  int unsigned accepted_ticks = 0;
  int unsigned send_gap       = 0;
  int unsigned recv_gap       = 0;
  logic        col_taken      = 1'b0;
  logic        out_taken      = 1'b0;
  logic        sender_idle_on   = 1'b1;
  logic        receiver_idle_on = 1'b1;
  logic        hold_results     = 1'b0;

  // Advances the scanner by one tick with the given column levels. It returns
  // the result item that the tick produces.
  function automatic key_report_t scan_tick(input logic [kps_pkg::ColW-1:0] levels);
    logic [kps_pkg::ColW-1:0] lows;
    logic                     held_low;
    key_report_t              rep;
    lows     = ~levels;
    held_low = lows[held_col];
    rep      = '0;
    case (scan_state)
      PhDebounce: begin
        // The held column is looked at again only once the count has run out.
        if (settle_count != 0) begin
          settle_count = settle_count - 1'b1;
        end else if (held_low) begin
          scan_state = PhRelease;
        end else begin
          scan_row   = scan_row + 1'b1;
          scan_state = PhScan;
        end
      end
      PhRelease: begin
        // A confirmed key is reported on the tick when it is released.
        if (!held_low) begin
          rep.key_valid = 1'b1;
          rep.key_code  = code_rows[scan_row][{held_col, 3'b000} +: kps_pkg::CodeW];
          scan_row      = scan_row + 1'b1;
          scan_state    = PhScan;
        end
      end
      default: begin
        if (lows == '0) begin
          scan_row = scan_row + 1'b1;
        end else begin
          // The lowest pressed column becomes the candidate; column three
          // stands unless a lower one is down.
          held_col = '1;
          for (int c = kps_pkg::ColW - 1; c >= 0; c--) begin
            if (lows[c]) held_col = c[kps_pkg::HeldW-1:0];
          end
          settle_count = debounce_len;
          scan_state   = PhDebounce;
        end
      end
    endcase
    rep.row_drive           = '1;
    rep.row_drive[scan_row] = 1'b0;
    return rep;
  endfunction

  function automatic int unsigned draw_gap(input logic enabled);
    return enabled ? $urandom_range(0, 12) : 0;
  endfunction

  // A key set held for some ticks, then all keys up for some ticks.
  task automatic queue_press(input logic [15:0] keys, input int unsigned hold,
                             input int unsigned rel);
    pad_tick_t t;
    t = '{raw: 1'b0, raw_levels: '1, keys: keys};
    repeat (hold) pending_ticks.push_back(t);
    t.keys = '0;
    repeat (rel) pending_ticks.push_back(t);
  endtask

  task automatic queue_raw(input logic [kps_pkg::ColW-1:0] levels);
    pending_ticks.push_back('{raw: 1'b1, raw_levels: levels, keys: '0});
  endtask

  // Random traffic, mostly clean presses of one key. Some presses hold several
  // keys at once, some are too short to be confirmed, and some ticks are noise.
  task automatic queue_random_traffic(input int unsigned count);
    int unsigned queued;
    int unsigned pick;
    int unsigned hold;
    int unsigned n;
    logic [15:0] keys;
    queued = 0;
    while (queued < count) begin
      pick = $urandom_range(0, 9);
      hold = debounce_len + $urandom_range(5, 12);
      keys = 16'h1 << $urandom_range(0, 15);
      if (pick == 6 || pick == 7) begin
        keys = 16'($urandom_range(1, 16'hFFFF));
      end else if (pick == 8) begin
        hold = $urandom_range(1, debounce_len + 4);
      end
      if (pick == 9) begin
        n = $urandom_range(1, 8);
        repeat (n) queue_raw(4'($urandom_range(0, 15)));
        queued += n;
      end else begin
        n = $urandom_range(1, 6);
        queue_press(keys, hold, n);
        queued += hold + n;
      end
    end
  endtask

  // The registers may only change while the block is idle, so callers drain
  // the block first.
  task automatic write_register(input logic [kps_pkg::CfgIdxW-1:0] idx,
                                input logic [kps_pkg::CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      kps_pkg::RegDebounce: debounce_len = value[kps_pkg::TicksW-1:0];
      kps_pkg::RegRow0:     code_rows[0] = value;
      kps_pkg::RegRow1:     code_rows[1] = value;
      kps_pkg::RegRow2:     code_rows[2] = value;
      kps_pkg::RegRow3:     code_rows[3] = value;
      default:              ;
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Holds the sender back until all queued ticks have gone in and every result
  // has come out.
  task automatic wait_for_drain();
    while (pending_ticks.size() != 0 || col_valid || expected_reports.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Driver. A new tick goes out at the falling edge once the previous tick has
  // been taken and its gap has run out. Its levels follow the row that the
  // predictor says is driven now.
  always @(negedge clk_i) begin
    logic                     next_valid;
    logic [kps_pkg::ColW-1:0] next_levels;
    pad_tick_t                tick;
    next_valid  = col_valid;
    next_levels = col_levels;
    if (rst_ni) begin
      if (col_taken) begin
        next_valid = 1'b0;
        send_gap   = draw_gap(sender_idle_on);
      end
      if (!next_valid) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (pending_ticks.size() != 0) begin
          tick        = pending_ticks.pop_front();
          next_valid  = 1'b1;
          next_levels = tick.raw ? tick.raw_levels
                                 : ~tick.keys[{scan_row, 2'b00} +: kps_pkg::ColW];
        end
      end
    end
    col_valid  <= next_valid;
    col_levels <= next_levels;
  end

  // The result side stalls at random. It also stalls for one long stretch,
  // during which the block must fill up and stop taking ticks.
  always @(negedge clk_i) begin
    if (out_taken) recv_gap = draw_gap(receiver_idle_on);
    if (!rst_ni || hold_results) begin
      out_ready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Predicts each accepted tick and checks each accepted result against the
  // oldest prediction. New predictions are queued first, so a result on the
  // same edge still finds its own prediction at the head.
  always @(posedge clk_i) begin
    key_report_t want;
    key_report_t got;
    logic        took_col;
    logic        took_out;
    took_col = 1'b0;
    took_out = 1'b0;
    if (rst_ni) begin
      if (col_valid && col_if.ready) begin
        expected_reports.push_back(scan_tick(col_levels));
        accepted_ticks++;
        took_col = 1'b1;
      end
      if (key_if.valid && out_ready) begin
        took_out = 1'b1;
        got = '{row_drive: key_if.row_drive, key_valid: key_if.key_valid,
                key_code: key_if.key_code};
        if (expected_reports.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("unexpected result: row_drive %h key_valid %b key_code %h",
                     got.row_drive, got.key_valid, got.key_code);
        end else begin
          want = expected_reports.pop_front();
          if (got.row_drive !== want.row_drive || got.key_valid !== want.key_valid ||
              got.key_code !== want.key_code) begin
            fault_count++;
            if (fault_count <= 10)
              $display("mismatch: row_drive %h/%h key_valid %b/%b key_code %h/%h (exp/got)",
                       want.row_drive, got.row_drive, want.key_valid, got.key_valid,
                       want.key_code, got.key_code);
          end
        end
      end
    end
    col_taken <= took_col;
    out_taken <= took_out;
  end

  // One long stall on the result side, counted in cycles in its own process.
  // It starts once enough ticks have gone in, while the sender is still busy.
  initial begin
    while (accepted_ticks < 600) @(posedge clk_i);
    hold_results = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_results = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: debounce of 25 ticks and an all-zero code table. Key 0 is
    // seen right away on row 0. It is held through the recheck, then released.
    queue_press(16'h0001, 27, 1);
    wait_for_drain();

    // Zero debounce, so the recheck comes on the tick after detection. Row 0
    // holds all-ones codes, the largest value a register can take.
    write_register(kps_pkg::RegDebounce, '0);
    write_register(kps_pkg::RegRow0, 32'hFFFF_FFFF);
    write_register(kps_pkg::RegRow1, $urandom());
    write_register(kps_pkg::RegRow2, $urandom());
    write_register(kps_pkg::RegRow3, $urandom());
    queue_press(16'hFFFF, 3, 1);   // every key down: column 0 of the row wins
    queue_press(16'h8000, 8, 1);   // bottom right corner
    queue_raw(4'b0111);            // column 3 low only at detection...
    queue_raw(4'b1111);            // ...so the candidate is dropped at the recheck
    queue_raw(4'b0101);            // columns 1 and 3 low: column 1 is held
    queue_raw(4'b0101);
    queue_raw(4'b1111);
    queue_raw(4'b0000);            // all columns low on whatever row is driven
    queue_raw(4'b0000);
    queue_raw(4'b1110);
    wait_for_drain();

    // Random phases. Each one uses a new debounce length and code table, and a
    // different mix of idling on the two sides.
    for (int p = 0; p < 6; p++) begin
      write_register(kps_pkg::RegDebounce, 32'(DebouncePlan[p]));
      for (int r = 0; r < 4; r++) begin
        write_register(kps_pkg::RegRow0 + 3'(r),
                       (p == 1) ? 32'hFFFF_FFFF : (p == 2) ? 32'h0 : $urandom());
      end
      sender_idle_on   = (p % 3 != 1);
      receiver_idle_on = (p % 3 != 2);
      queue_random_traffic(330);
      wait_for_drain();
    end

    // Longest debounce. The keys go down, the wait counter is loaded with its
    // largest value and counts down from there while they stay down.
    write_register(kps_pkg::RegDebounce, 32'h0000_FFFF);
    sender_idle_on   = 1'b0;
    receiver_idle_on = 1'b0;
    queue_press(16'hFFFF, 40, 2);
    wait_for_drain();

    repeat (8) @(posedge clk_i);
    if (fault_count == 0 && expected_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
